>>> hdl/crls_pkg.sv
// Package for the circular record log store.
// Holds item, record and control types plus command and result codes.
// Depends on nothing; crls_ctrl, crls_dp and the top level import it.
package crls_pkg;

  localparam logic [1:0] CMD_APPEND     = 2'd0;
  localparam logic [1:0] CMD_LIST_FIRST = 2'd1;
  localparam logic [1:0] CMD_LIST_NEXT  = 2'd2;
  localparam logic [1:0] CMD_RESERVED   = 2'd3;

  localparam logic [2:0] RES_STORED    = 3'd0;
  localparam logic [2:0] RES_FILTERED  = 3'd1;
  localparam logic [2:0] RES_TOO_LARGE = 3'd2;
  localparam logic [2:0] RES_LISTED    = 3'd3;
  localparam logic [2:0] RES_NONE      = 3'd4;

  localparam logic [6:0] FAC_LOCAL7 = 7'd23;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [14:0] msg_bytes;
    logic [9:0]  priority_req;
    logic [1:0]  source;
    logic [31:0] count;
    logic [13:0] offset;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] rec_offset;
    logic [31:0] rec_id;
    logic [14:0] rec_bytes;
    logic [9:0]  rec_priority;
    logic [1:0]  rec_source;
    logic [31:0] discarded;
    logic [31:0] rounds;
  } rsp_item_t;

  typedef struct packed {
    logic [31:0] id;
    logic [14:0] size;
    logic [9:0]  priority_val;
    logic [1:0]  source;
  } slot_rec_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_WRAP_RD, ST_WRAP_UPD, ST_FREE, ST_FREE_UPD,
    ST_L_ADV, ST_L_CHK, ST_L_TEST, ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_CAPTURE, OP_FAIL, OP_SET_NXT, OP_RD_TAIL, OP_RD_ZERO,
    OP_WRAP, OP_RD_FREE, OP_FREE_STEP, OP_STORE, OP_LIST_FIRST,
    OP_RD_START, OP_ADV, OP_CHK, OP_LISTED, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] res;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       filtered;
    logic       too_large;
    logic       wrap;
    logic       off_bad;
    logic       free_more;
    logic       limit;
    logic       adv_hit;
    logic       chk_empty;
    logic       id_ok;
    logic       out_busy;
  } dp_stat_t;

endpackage

>>> hdl/crls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module crls_ram #(
  parameter int WIDTH = 59,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/crls_ctrl.sv
// Controller state machine of the circular record log store.
// Sequences append and list walks; depends on crls_pkg.
module crls_ctrl
  import crls_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    cmd.res    = RES_NONE;
    req_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (st.cmd == CMD_APPEND) begin
          if (st.filtered) begin
            cmd.op     = OP_FAIL;
            cmd.res    = RES_FILTERED;
            state_next = ST_DONE;
          end else if (st.too_large) begin
            cmd.op     = OP_FAIL;
            cmd.res    = RES_TOO_LARGE;
            state_next = ST_DONE;
          end else if (st.wrap) begin
            cmd.op     = OP_RD_TAIL;
            state_next = ST_WRAP_RD;
          end else begin
            cmd.op     = OP_SET_NXT;
            state_next = ST_FREE;
          end
        end else if (st.cmd == CMD_LIST_FIRST) begin
          cmd.op     = OP_LIST_FIRST;
          state_next = ST_L_CHK;
        end else if (st.cmd == CMD_LIST_NEXT && !st.off_bad) begin
          cmd.op     = OP_RD_START;
          state_next = ST_L_ADV;
        end else begin
          cmd.op     = OP_FAIL;
          state_next = ST_DONE;
        end
      end
      ST_WRAP_RD: begin
        cmd.op     = OP_RD_ZERO;
        state_next = ST_WRAP_UPD;
      end
      ST_WRAP_UPD: begin
        cmd.op     = OP_WRAP;
        state_next = ST_FREE;
      end
      ST_FREE: begin
        if (st.free_more) begin
          cmd.op     = OP_RD_FREE;
          state_next = ST_FREE_UPD;
        end else begin
          cmd.op     = OP_STORE;
          cmd.res    = RES_STORED;
          state_next = ST_DONE;
        end
      end
      ST_FREE_UPD: begin
        cmd.op     = OP_FREE_STEP;
        state_next = ST_FREE;
      end
      ST_L_ADV: begin
        if (st.limit || st.adv_hit) begin
          cmd.op     = OP_FAIL;
          state_next = ST_DONE;
        end else begin
          cmd.op     = OP_ADV;
          state_next = ST_L_CHK;
        end
      end
      ST_L_CHK: begin
        if (st.chk_empty) begin
          cmd.op     = OP_FAIL;
          state_next = ST_DONE;
        end else begin
          cmd.op     = OP_CHK;
          state_next = ST_L_TEST;
        end
      end
      ST_L_TEST: begin
        if (st.id_ok) begin
          cmd.op     = OP_LISTED;
          cmd.res    = RES_LISTED;
          state_next = ST_DONE;
        end else begin
          state_next = ST_L_ADV;
        end
      end
      ST_DONE: begin
        if (!st.out_busy) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/crls_dp.sv
// Datapath of the circular record log store: pointers, counters, header RAM
// and result register. Depends on crls_pkg and crls_ram.
module crls_dp
  import crls_pkg::*;
#(
  parameter int BUF_BYTES    = 16384,
  parameter int HEADER_BYTES = 32,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  output dp_stat_t  st,
  input  req_item_t req,
  input  logic      cfg_valid,
  input  logic [2:0] cfg_data,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam int SLOTS      = (BUF_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int SW         = $clog2(SLOTS);
  localparam int OW         = $clog2(BUF_BYTES + 32768 + 128) + 1;
  localparam int WALK_LIMIT = 2 * (BUF_BYTES / HEADER_BYTES) + 4;
  localparam int CW         = $clog2(WALK_LIMIT + 1);
  localparam logic [OW-1:0] BUF_O = OW'(BUF_BYTES);

  function automatic logic [OW-1:0] after_rec(input logic [OW-1:0] off,
                                              input logic [14:0] size);
    logic [OW-1:0] e;
    e = off + OW'(HEADER_BYTES) + OW'(size) + OW'(ALIGN_BYTES - 1);
    return (e / OW'(ALIGN_BYTES)) * OW'(ALIGN_BYTES);
  endfunction

  function automatic logic [SW-1:0] slot_of(input logic [OW-1:0] off);
    logic [OW-1:0] q;
    q = off / OW'(ALIGN_BYTES);
    return q[SW-1:0];
  endfunction

  req_item_t     q;
  logic [2:0]    max_level;
  logic [OW-1:0] wo, ts, te, nxt, h;
  logic [31:0]   next_id, disc, wraps, lowest, old_id;
  logic [CW-1:0] steps;
  rsp_item_t     res;

  slot_rec_t     rd, wdata;
  logic          re, we;
  logic [SW-1:0] raddr;

  logic [OW-1:0] nxt_app, off_al, adv_h, free_h, chk_h;

  assign nxt_app = after_rec(wo, q.msg_bytes);
  assign off_al  = (OW'(q.offset) / OW'(ALIGN_BYTES)) * OW'(ALIGN_BYTES);
  assign adv_h   = after_rec(h, rd.size);
  assign free_h  = after_rec(ts, rd.size);
  assign chk_h   = (h >= te) ? '0 : h;

  assign st.cmd       = q.cmd;
  assign st.filtered  = (q.priority_req[9:3] == FAC_LOCAL7) || (q.priority_req[2:0] > max_level);
  assign st.too_large = (nxt_app - wo) > BUF_O;
  assign st.wrap      = nxt_app >= BUF_O;
  assign st.off_bad   = OW'(q.offset) >= BUF_O;
  assign st.free_more = ts < nxt;
  assign st.limit     = steps == CW'(WALK_LIMIT);
  assign st.adv_hit   = adv_h == wo;
  assign st.chk_empty = (h >= te) && (wo == '0);
  assign st.id_ok     = rd.id >= lowest;
  assign st.out_busy  = rsp_valid && rsp_stall;

  always_comb begin
    re    = 1'b0;
    raddr = slot_of(ts);
    unique case (cmd.op)
      OP_RD_TAIL, OP_RD_FREE: re = 1'b1;
      OP_RD_ZERO: begin
        re    = 1'b1;
        raddr = '0;
      end
      OP_RD_START: begin
        re    = 1'b1;
        raddr = slot_of(off_al);
      end
      OP_CHK: begin
        re    = 1'b1;
        raddr = slot_of(chk_h);
      end
      default: re = 1'b0;
    endcase
  end

  assign we                 = cmd.op == OP_STORE;
  assign wdata.id           = next_id;
  assign wdata.size         = q.msg_bytes;
  assign wdata.priority_val = q.priority_req;
  assign wdata.source       = q.source;

  crls_ram #(.WIDTH($bits(slot_rec_t)), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (slot_of(wo)),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_level <= 3'd7;
      wo        <= '0;
      ts        <= BUF_O;
      te        <= BUF_O;
      next_id   <= '0;
      disc      <= '0;
      wraps     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_level <= cfg_data;
      end
      if (cmd.op == OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_WRAP: begin
          disc  <= disc + rd.id - old_id;
          te    <= wo;
          wo    <= '0;
          ts    <= '0;
          wraps <= wraps + 32'd1;
        end
        OP_FREE_STEP: begin
          disc <= disc + 32'd1;
          if (free_h >= te) begin
            ts <= BUF_O;
            te <= BUF_O;
          end else begin
            ts <= free_h;
          end
        end
        OP_STORE: begin
          next_id <= next_id + 32'd1;
          wo      <= nxt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        q <= req;
        if (req.count != '0 && req.count < next_id) begin
          lowest <= next_id - req.count;
        end else begin
          lowest <= '0;
        end
      end
      OP_SET_NXT: nxt <= nxt_app;
      OP_RD_ZERO: old_id <= (ts < te) ? rd.id : '0;
      OP_WRAP: nxt <= after_rec('0, q.msg_bytes);
      OP_FAIL: res <= rsp_item_t'({cmd.res, {($bits(rsp_item_t) - 3){1'b0}}});
      OP_STORE: begin
        res.status       <= cmd.res;
        res.rec_offset   <= wo[14:0];
        res.rec_id       <= next_id;
        res.rec_bytes    <= q.msg_bytes;
        res.rec_priority <= q.priority_req;
        res.rec_source   <= q.source;
      end
      OP_LIST_FIRST: begin
        h     <= ts;
        steps <= '0;
      end
      OP_RD_START: begin
        h     <= off_al;
        steps <= '0;
      end
      OP_ADV: h <= adv_h;
      OP_CHK: begin
        h     <= chk_h;
        steps <= steps + CW'(1);
      end
      OP_LISTED: begin
        res.status       <= cmd.res;
        res.rec_offset   <= h[14:0];
        res.rec_id       <= rd.id;
        res.rec_bytes    <= rd.size;
        res.rec_priority <= rd.priority_val;
        res.rec_source   <= rd.source;
      end
      OP_EMIT: rsp <= {res.status, res.rec_offset, res.rec_id, res.rec_bytes,
                       res.rec_priority, res.rec_source, disc, wraps};
      default: ;
    endcase
  end

  a_wo_range: assert property (@(posedge clk) disable iff (rst) wo <= BUF_O)
    else $error("write offset beyond buffer");
  a_tail_order: assert property (@(posedge clk) disable iff (rst) ts <= te)
    else $error("tail start past tail end");
  a_tail_range: assert property (@(posedge clk) disable iff (rst) te <= BUF_O)
    else $error("tail end beyond buffer");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |-> !(rsp_valid && rsp_stall))
    else $error("result overwritten while stalled");

endmodule

>>> hdl/circular_record_log_store_core.sv
// Top level of the circular record log store.
// Joins crls_ctrl and crls_dp; depends on crls_pkg.
//
// Usage: requests enter on req (req_valid/req_stall), one transaction per
// command: append a record header, list from the oldest record, or list the
// record after a given offset. Each request yields exactly one response
// transaction on rsp (rsp_valid/rsp_stall) carrying status, record fields
// and the discard and wrap counters.
// The block handles one request at a time. An append is decoded, on a wrap
// reads the tail header and the header at offset zero and updates the
// pointers, then frees old records one header at a time from the header RAM
// and stores. A list walks headers one at a time from the oldest record or
// from the given offset, bounded by the walk limit; filtered, refused and
// unused commands go straight to the response. A new request is accepted
// the cycle after the previous one has reached the response register, even
// while that response is stalled; its result waits until that response is
// taken. max_level is written through cfg_valid/cfg_ready (always ready);
// the user is to write it only while idle, which the block does not enforce.
// Reset (rst, synchronous) empties the log, clears counters and sets
// max_level to 7; header RAM contents are not cleared.
module circular_record_log_store_core
  import crls_pkg::*;
#(
  parameter int BUF_BYTES    = 16384,
  parameter int HEADER_BYTES = 32,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_item_t  req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_item_t  rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  assign cfg_ready = 1'b1;

  crls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  crls_dp #(
    .BUF_BYTES    (BUF_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .req       (req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> dv/crls_checker.sv
// Checker for the circular record log store: watches request, response and
// configuration transactions, predicts each response and compares it.
// Depends on crls_pkg; instantiated beside the block by the testbench top.
module crls_checker
  import crls_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_stall,
  input  req_item_t req,
  input  logic      rsp_valid,
  input  logic      rsp_stall,
  input  rsp_item_t rsp,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [2:0] cfg_data,
  output int        fails,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned LOG_BYTES = 16384;
  localparam longint unsigned HDR_BYTES = 32;
  localparam longint unsigned ALN_BYTES = 8;
  localparam int SLOTS = 2048;
  localparam int WALK_MAX = 2 * (16384 / 32) + 4;

  logic [31:0] slot_id[SLOTS];
  logic [14:0] slot_size[SLOTS];
  logic [9:0]  slot_prio[SLOTS];
  logic [1:0]  slot_src[SLOTS];
  bit          slot_written[SLOTS];

  longint unsigned wr_at, tail_lo, tail_hi;
  logic [31:0] id_next, discards, wraps;
  logic [2:0]  level_cap;
  longint unsigned last_at;

  rsp_item_t expected_rsps[$];

  function automatic longint unsigned rec_end(longint unsigned off, longint unsigned sz);
    return ((off + HDR_BYTES + sz + ALN_BYTES - 1) / ALN_BYTES) * ALN_BYTES;
  endfunction

  function automatic slot_rec_t slot_at(longint unsigned off);
    slot_rec_t s;
    longint unsigned i;
    i = off / ALN_BYTES;
    s = '0;
    if (i < SLOTS) begin
      s.id = slot_id[i];
      s.size = slot_size[i];
      s.priority_val = slot_prio[i];
      s.source = slot_src[i];
    end
    return s;
  endfunction

  function automatic bit slot_known(longint unsigned off);
    longint unsigned i;
    i = off / ALN_BYTES;
    return (i >= SLOTS) || slot_written[i];
  endfunction

  function automatic rsp_item_t blank_rsp(logic [2:0] st);
    rsp_item_t r;
    r = '0;
    r.status = st;
    r.discarded = discards;
    r.rounds = wraps;
    return r;
  endfunction

  function automatic rsp_item_t record_rsp(logic [2:0] st, longint unsigned off, slot_rec_t s);
    rsp_item_t r;
    r = blank_rsp(st);
    r.rec_offset = off[14:0];
    r.rec_id = s.id;
    r.rec_bytes = s.size;
    r.rec_priority = s.priority_val;
    r.rec_source = s.source;
    return r;
  endfunction

  function automatic rsp_item_t append_record(req_item_t it);
    longint unsigned sz, nxt, at, i;
    logic [31:0] old;
    slot_rec_t s;
    sz = it.msg_bytes;
    if (it.priority_req[9:3] == FAC_LOCAL7 || it.priority_req[2:0] > level_cap)
      return blank_rsp(RES_FILTERED);
    nxt = rec_end(wr_at, sz);
    if (nxt - wr_at > LOG_BYTES) return blank_rsp(RES_TOO_LARGE);
    if (nxt >= LOG_BYTES) begin
      old = (tail_lo < tail_hi) ? slot_at(tail_lo).id : 32'd0;
      discards = discards + slot_at(0).id - old;
      tail_hi = wr_at;
      wr_at = 0;
      tail_lo = 0;
      nxt = rec_end(0, sz);
      wraps = wraps + 1;
    end
    while (tail_lo < nxt) begin
      discards = discards + 1;
      tail_lo = rec_end(tail_lo, slot_at(tail_lo).size);
      if (tail_lo >= tail_hi) begin
        tail_lo = LOG_BYTES;
        tail_hi = LOG_BYTES;
        break;
      end
    end
    s.id = id_next;
    s.size = it.msg_bytes;
    s.priority_val = it.priority_req;
    s.source = it.source;
    id_next = id_next + 1;
    at = wr_at;
    i = at / ALN_BYTES;
    slot_id[i] = s.id;
    slot_size[i] = s.size;
    slot_prio[i] = s.priority_val;
    slot_src[i] = s.source;
    slot_written[i] = 1'b1;
    last_at = at;
    wr_at = nxt;
    return record_rsp(RES_STORED, at, s);
  endfunction

  function automatic rsp_item_t list_record(logic [31:0] cnt, bit from_oldest,
                                            longint unsigned start);
    logic [31:0] lowest;
    longint unsigned h;
    bit have;
    slot_rec_t s;
    lowest = 0;
    h = start;
    have = !from_oldest;
    if (cnt != 0) lowest = (cnt < id_next) ? id_next - cnt : 32'd0;
    for (int n = 0; n < WALK_MAX; n++) begin
      if (have) begin
        h = rec_end(h, slot_at(h).size);
        if (h == wr_at) break;
      end else begin
        h = tail_lo;
        have = 1'b1;
      end
      if (h >= tail_hi) begin
        h = 0;
        if (h == wr_at) break;
      end
      s = slot_at(h);
      if (s.id >= lowest) return record_rsp(RES_LISTED, h, s);
    end
    return blank_rsp(RES_NONE);
  endfunction

  // True when a list-next from off only touches headers already written.
  function automatic bit next_walk_safe(logic [13:0] off);
    longint unsigned h;
    h = (longint'(off) / ALN_BYTES) * ALN_BYTES;
    for (int n = 0; n < WALK_MAX; n++) begin
      if (!slot_known(h)) return 1'b0;
      h = rec_end(h, slot_at(h).size);
      if (h == wr_at) return 1'b1;
      if (h >= tail_hi) begin
        h = 0;
        if (h == wr_at) return 1'b1;
      end
      if (!slot_known(h)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic rsp_item_t predict_rsp(req_item_t it);
    case (it.cmd)
      CMD_APPEND:     return append_record(it);
      CMD_LIST_FIRST: return list_record(it.count, 1'b1, 0);
      CMD_LIST_NEXT:  return list_record(it.count, 1'b0, (longint'(it.offset) / ALN_BYTES) * ALN_BYTES);
      default:        return blank_rsp(RES_NONE);
    endcase
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    pending = 0;
    for (int i = 0; i < SLOTS; i++) slot_written[i] = 1'b0;
    last_at = 0;
  end

  always @(posedge clk) begin
    rsp_item_t e;
    if (rst) begin
      wr_at = 0;
      tail_lo = LOG_BYTES;
      tail_hi = LOG_BYTES;
      id_next = 0;
      discards = 0;
      wraps = 0;
      level_cap = 3'd7;
      expected_rsps.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("response transaction with nothing expected");
          fails++;
        end else begin
          e = expected_rsps.pop_front();
          check_field("status", e.status, rsp.status);
          check_field("rec_offset", e.rec_offset, rsp.rec_offset);
          check_field("rec_id", e.rec_id, rsp.rec_id);
          check_field("rec_bytes", e.rec_bytes, rsp.rec_bytes);
          check_field("rec_priority", e.rec_priority, rsp.rec_priority);
          check_field("rec_source", e.rec_source, rsp.rec_source);
          check_field("discarded", e.discarded, rsp.discarded);
          check_field("rounds", e.rounds, rsp.rounds);
        end
      end
      if (req_valid && !req_stall) expected_rsps.push_back(predict_rsp(req));
      if (cfg_valid && cfg_ready) level_cap = cfg_data;
    end
    pending <= expected_rsps.size();
  end
endmodule

>>> dv/circular_record_log_store_core_tb.sv
// Testbench top for the circular record log store: clock, reset, request,
// response and configuration stimulus, and the verdict.
// Depends on crls_pkg, circular_record_log_store_core and crls_checker.
module circular_record_log_store_core_tb;
  import crls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_item_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_item_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_data = 3'd0;
  int fails, pending;
  int cycles = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  bit late_off;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  circular_record_log_store_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  crls_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int idle_gap();
    if (quiet) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Pick a list-next offset whose walk reads only written headers.
  function automatic logic [13:0] pick_offset();
    logic [13:0] o;
    case ($urandom_range(0, 3))
      0: o = 14'($urandom_range(0, 16383));
      1: o = (chk.tail_lo < 16384) ? 14'(chk.tail_lo) : 14'(chk.last_at);
      default: o = 14'(chk.last_at);
    endcase
    o[2:0] = 3'($urandom_range(0, 7));
    if (!chk.next_walk_safe(o)) o = 14'(chk.last_at) | 14'($urandom_range(0, 7));
    return o;
  endfunction

  task automatic send_req(req_item_t it);
    int g;
    logic st;
    g = idle_gap();
    if (late_off && g == 0) g = 1;
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g - 1) @(posedge clk);
      @(negedge clk);
      if (late_off) it.offset = pick_offset();
      @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    do begin
      @(negedge clk);
      st = req_stall;
      @(posedge clk);
    end while (st);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_level(logic [2:0] lv);
    logic rd;
    cfg_data <= lv;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      rd = cfg_ready;
      @(posedge clk);
    end while (!rd);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_item_t mk_req(logic [1:0] c, int sz, int pr, int sr,
                                       logic [31:0] cnt);
    req_item_t it;
    it.cmd = c;
    it.msg_bytes = 15'(sz);
    it.priority_req = 10'(pr);
    it.source = 2'(sr);
    it.count = cnt;
    it.offset = 14'($urandom_range(0, 16383));
    return it;
  endfunction

  task automatic send_one(req_item_t it);
    late_off = (it.cmd == CMD_LIST_NEXT);
    send_req(it);
  endtask

  function automatic req_item_t rand_req();
    req_item_t it;
    int r;
    it = mk_req(CMD_APPEND, 1, 0, 0, 0);
    it.priority_req = 10'($urandom_range(0, 1023));
    it.source = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 40) it.count = 0;
    else if (r < 70) it.count = $urandom_range(1, 20);
    else it.count = $urandom();
    r = $urandom_range(0, 99);
    if (r < 55) begin
      it.cmd = CMD_APPEND;
      if ($urandom_range(0, 9) == 0) it.priority_req[9:3] = FAC_LOCAL7;
      r = $urandom_range(0, 99);
      if (r < 70) it.msg_bytes = 15'($urandom_range(1, 1500));
      else if (r < 90) it.msg_bytes = 15'($urandom_range(1, 64));
      else if (r < 97) it.msg_bytes = 15'($urandom_range(1500, 16352));
      else it.msg_bytes = 15'($urandom_range(16353, 32767));
    end else if (r < 75) begin
      it.cmd = CMD_LIST_FIRST;
      it.msg_bytes = 15'($urandom_range(0, 32767));
    end else if (r < 95) begin
      it.cmd = CMD_LIST_NEXT;
      it.msg_bytes = 15'($urandom_range(0, 32767));
    end else begin
      it.cmd = CMD_RESERVED;
      it.msg_bytes = 15'($urandom_range(0, 32767));
    end
    return it;
  endfunction

  initial begin
    logic st;
    int n;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        n = 3000;
      end else n = idle_gap();
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do begin
        @(negedge clk);
        st = rsp_valid;
        @(posedge clk);
      end while (!st);
    end
  end

  initial begin
    logic [2:0] levels[5];
    levels = '{3'd7, 3'd0, 3'd4, 3'd2, 3'd7};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_one(mk_req(CMD_APPEND, 1, 0, 0, 0));
    send_one(mk_req(CMD_APPEND, 32767, 7, 1, 0));
    send_one(mk_req(CMD_APPEND, 16353, 3, 2, 0));
    send_one(mk_req(CMD_APPEND, 40, 184, 1, 0));
    send_one(mk_req(CMD_APPEND, 100, 1023, 3, 0));
    send_one(mk_req(CMD_LIST_FIRST, 0, 0, 0, 0));
    send_one(mk_req(CMD_LIST_FIRST, 0, 0, 0, 1));
    send_one(mk_req(CMD_LIST_FIRST, 0, 0, 0, 32'hFFFF_FFFF));
    send_one(mk_req(CMD_LIST_NEXT, 0, 0, 0, 0));
    send_one(mk_req(CMD_RESERVED, 32767, 1023, 3, 32'hFFFF_FFFF));
    send_one(mk_req(CMD_APPEND, 16352, 5, 0, 0));
    for (int i = 0; i < 6; i++) send_one(mk_req(CMD_APPEND, 500 + i * 700, 6, i % 4, 0));
    send_one(mk_req(CMD_LIST_NEXT, 0, 0, 0, 0));
    send_one(mk_req(CMD_LIST_FIRST, 0, 0, 0, 2));
    send_one(mk_req(CMD_LIST_NEXT, 0, 0, 0, 3));
    drain();

    for (int p = 0; p < 5; p++) begin
      write_level(levels[p]);
      for (int i = 0; i < 206; i++) begin
        if (i % 40 == 0) quiet = !quiet;
        if (p == 1 && i == 50) long_hold = 1'b1;
        if (p == 3 && i == 100) begin
          req_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_one(rand_req());
      end
      drain();
    end

    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
